FILE: hdl/rmva_pkg.sv
// Package for the register-mapped vector ALU.
// Holds field widths, status and operation codes, and the ALU command type.
// No dependencies.
package rmva_pkg;

  localparam int LANE_W     = 8;
  localparam int ADDR_W     = 7;
  localparam int STEP_SHIFT = 3;
  localparam int SLOT_W     = ADDR_W - STEP_SHIFT;
  localparam int STAT_W     = 2;
  localparam int OP_W       = 2;
  localparam int OP_LSB     = 2;
  localparam int CNT_W      = $clog2(LANE_W);

  typedef logic [LANE_W-1:0] lane_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [OP_W-1:0]   op_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_BAD_ADDR = 2'd1;
  localparam status_t ST_DIV_ZERO = 2'd2;

  localparam op_t OP_ADD = 2'd0;
  localparam op_t OP_SUB = 2'd1;
  localparam op_t OP_MUL = 2'd2;
  localparam op_t OP_DIV = 2'd3;

  localparam lane_t READY_BIT   = 8'h01;
  localparam lane_t READY_CLEAR = 8'hfe;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_cmd_t;

endpackage

FILE: hdl/rmva_req_if.sv
// Bus request channel: access type, byte offset and write byte.
// Depends on rmva_pkg.
interface rmva_req_if import rmva_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ADDR_W-1:0] address;
  lane_t             write_data;

  modport source (output valid, output operation, output address, output write_data,
                  input ready);
  modport sink (input valid, input operation, input address, input write_data,
                output ready);
endinterface

FILE: hdl/rmva_rsp_if.sv
// Bus response channel: read byte and status.
// Depends on rmva_pkg.
interface rmva_rsp_if import rmva_pkg::*; ();
  logic    valid;
  logic    ready;
  lane_t   read_data;
  status_t status;

  modport source (output valid, output read_data, output status, input ready);
  modport sink (input valid, input read_data, input status, output ready);
endinterface

FILE: hdl/rmva_regfile.sv
// Lane register file: operand and result vectors in one memory.
// Per-entry valid bits make unwritten entries read as zero. Depends on rmva_pkg.
module rmva_regfile import rmva_pkg::*; #(
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  lane_t                    wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output lane_t                    rdata
);
  lane_t            mem [DEPTH];
  logic [DEPTH-1:0] vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= vld[raddr] ? mem[raddr] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end
endmodule

FILE: hdl/rmva_serial_alu.sv
// Bit-serial lane ALU: add/sub one bit per cycle, shift-add multiply,
// restoring divide, all in LANE_W steps. Depends on rmva_pkg.
module rmva_serial_alu import rmva_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_cmd_t cmd,
  input  lane_t    a,
  input  lane_t    b,
  output logic     done,
  output lane_t    result
);
  logic             busy;
  logic [CNT_W-1:0] cnt;
  op_t              op;
  lane_t            sa;
  lane_t            sb;
  lane_t            acc;
  lane_t            rem;
  logic             carry;
  logic             bbit;
  logic             sum;
  logic [LANE_W:0]  shifted;
  logic [LANE_W:0]  diff;

  assign bbit    = sb[0] ^ (op == OP_SUB);
  assign sum     = sa[0] ^ bbit ^ carry;
  assign shifted = {rem, sa[LANE_W-1]};
  assign diff    = shifted - {1'b0, sb};
  assign result  = (op == OP_DIV) ? sa : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(LANE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op    <= cmd.op;
      sa    <= a;
      sb    <= b;
      acc   <= '0;
      rem   <= '0;
      carry <= (cmd.op == OP_SUB);
    end else if (busy) begin
      case (op)
        OP_ADD, OP_SUB: begin
          carry <= (sa[0] & bbit) | (carry & (sa[0] ^ bbit));
          acc   <= {sum, acc[LANE_W-1:1]};
          sa    <= sa >> 1;
          sb    <= sb >> 1;
        end
        OP_MUL: begin
          acc <= acc + (sb[0] ? sa : '0);
          sa  <= sa << 1;
          sb  <= sb >> 1;
        end
        default: begin
          if (!diff[LANE_W]) begin
            rem <= diff[LANE_W-1:0];
            sa  <= {sa[LANE_W-2:0], 1'b1};
          end else begin
            rem <= shifted[LANE_W-1:0];
            sa  <= {sa[LANE_W-2:0], 1'b0};
          end
        end
      endcase
    end
  end
endmodule

FILE: hdl/register_mapped_vector_alu.sv
// Register-mapped vector ALU: top level with bus decode and lane sequencer.
// Depends on rmva_pkg, rmva_req_if, rmva_rsp_if, rmva_regfile, rmva_serial_alu.
//
// Byte-wide bus device: control byte at offset 0x00, then LANES lanes each of
// the first operand, second operand and result vectors at steps of 8. Reads
// of the control byte go straight to the response hand-off; lane reads first
// wait (RDWAIT) for the registered memory. A good write stores the byte, clears
// ready (control bit 0), then runs every lane through one shared bit-serial ALU:
// per lane 2 memory reads (LDA, LDB), an ALU start (GO) and the ALU run (RUN).
// Division (control bits 3:2 = 11) first tests each second-vector lane (ZRD,
// ZTST); a zero lane ends the request with status 2, results unchanged and
// ready left clear. Unknown offsets answer status 1 with no side effect.
module register_mapped_vector_alu import rmva_pkg::*; #(
  parameter int LANES = 4
) (
  input  logic       clk,
  input  logic       rst,
  rmva_req_if.sink   req,
  rmva_rsp_if.source rsp
);
  localparam int DEPTH    = 3 * LANES;
  localparam int AW       = $clog2(DEPTH);
  localparam int LW       = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int MAX_SLOT = 3 * LANES;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDWAIT = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_ZRD    = 4'd3;
  localparam logic [3:0] S_ZTST   = 4'd4;
  localparam logic [3:0] S_LDA    = 4'd5;
  localparam logic [3:0] S_LDB    = 4'd6;
  localparam logic [3:0] S_GO     = 4'd7;
  localparam logic [3:0] S_RUN    = 4'd8;
  localparam logic [3:0] S_PUSH   = 4'd9;

  logic [3:0]        state;
  lane_t             ctrl;
  logic [LW-1:0]     lane;
  lane_t             a_op;
  lane_t             res_data;
  status_t           res_status;
  logic              ov;
  lane_t             od;
  status_t           os;

  logic [SLOT_W-1:0] slot;
  logic              addr_ok;
  logic [AW-1:0]     slot_addr;
  logic [AW-1:0]     a_addr;
  logic [AW-1:0]     b_addr;
  logic [AW-1:0]     r_addr;
  logic              last_lane;
  logic              computing;

  logic              rf_we;
  logic [AW-1:0]     rf_waddr;
  lane_t             rf_wdata;
  logic [AW-1:0]     rf_raddr;
  lane_t             rf_rdata;

  alu_cmd_t          alu_cmd;
  logic              alu_done;
  lane_t             alu_res;

  assign slot      = req.address[ADDR_W-1:STEP_SHIFT];
  assign addr_ok   = (req.address[STEP_SHIFT-1:0] == '0) && (32'(slot) <= 32'(MAX_SLOT));
  assign slot_addr = AW'(32'(slot) - 32'd1);
  assign a_addr    = AW'(32'(lane));
  assign b_addr    = AW'(32'(lane) + 32'(LANES));
  assign r_addr    = AW'(32'(lane) + 32'(2 * LANES));
  assign last_lane = (lane == LW'(LANES - 1));
  assign computing = (state == S_START) || (state == S_ZRD) || (state == S_ZTST) ||
                     (state == S_LDA) || (state == S_LDB) || (state == S_GO) ||
                     (state == S_RUN);

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = ov;
  assign rsp.read_data = od;
  assign rsp.status    = os;

  assign alu_cmd.start = (state == S_GO);
  assign alu_cmd.op    = ctrl[OP_LSB+OP_W-1:OP_LSB];

  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = slot_addr;
    rf_wdata = req.write_data;
    rf_raddr = slot_addr;
    case (state)
      S_IDLE: rf_we = req.valid && addr_ok && req.operation && (slot != '0);
      S_ZRD:  rf_raddr = b_addr;
      S_LDA:  rf_raddr = a_addr;
      S_LDB:  rf_raddr = b_addr;
      S_RUN: begin
        rf_we    = alu_done;
        rf_waddr = r_addr;
        rf_wdata = alu_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ctrl  <= '0;
      lane  <= '0;
      ov    <= 1'b0;
    end else begin
      if (rsp.ready && (state != S_PUSH)) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (!addr_ok) begin
              res_data   <= '0;
              res_status <= ST_BAD_ADDR;
              state      <= S_PUSH;
            end else if (!req.operation) begin
              res_status <= ST_OK;
              if (slot == '0) begin
                res_data <= ctrl;
                state    <= S_PUSH;
              end else begin
                state <= S_RDWAIT;
              end
            end else begin
              res_data   <= '0;
              res_status <= ST_OK;
              if (slot == '0) begin
                ctrl <= req.write_data & READY_CLEAR;
              end else begin
                ctrl <= ctrl & READY_CLEAR;
              end
              state <= S_START;
            end
          end
        end
        S_RDWAIT: begin
          res_data <= rf_rdata;
          state    <= S_PUSH;
        end
        S_START: begin
          lane  <= '0;
          state <= (alu_cmd.op == OP_DIV) ? S_ZRD : S_LDA;
        end
        S_ZRD: state <= S_ZTST;
        S_ZTST: begin
          if (rf_rdata == '0) begin
            res_status <= ST_DIV_ZERO;
            state      <= S_PUSH;
          end else if (last_lane) begin
            lane  <= '0;
            state <= S_LDA;
          end else begin
            lane  <= lane + LW'(1);
            state <= S_ZRD;
          end
        end
        S_LDA: state <= S_LDB;
        S_LDB: begin
          a_op  <= rf_rdata;
          state <= S_GO;
        end
        S_GO: state <= S_RUN;
        S_RUN: begin
          if (alu_done) begin
            if (last_lane) begin
              ctrl  <= ctrl | READY_BIT;
              state <= S_PUSH;
            end else begin
              lane  <= lane + LW'(1);
              state <= S_LDA;
            end
          end
        end
        S_PUSH: begin
          if (!ov || rsp.ready) begin
            ov    <= 1'b1;
            od    <= res_data;
            os    <= res_status;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rmva_regfile #(
    .DEPTH (DEPTH)
  ) u_regfile (
    .clk   (clk),
    .rst   (rst),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr),
    .rdata (rf_rdata)
  );

  rmva_serial_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (alu_cmd),
    .a      (a_op),
    .b      (rf_rdata),
    .done   (alu_done),
    .result (alu_res)
  );

`ifndef SYNTH
  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> state == S_RUN)
    else $error("ALU finished outside a lane run");

  a_ready_clear: assert property (@(posedge clk) disable iff (rst)
    computing |-> !ctrl[0])
    else $error("ready bit set during computation");

  a_divz_keeps_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && res_status == ST_DIV_ZERO) |-> !ctrl[0])
    else $error("ready bit set after divide by zero");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && res_status == ST_BAD_ADDR) |-> res_data == '0)
    else $error("bad address response carries data");

  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && alu_done) |=> state == S_PUSH || state == S_LDA)
    else $error("sequencer lost after lane result");
`endif
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for register_mapped_vector_alu: directed register table, then random
// bus requests over several idle/stall phases. Depends on rmva_pkg, rmva_req_if, rmva_rsp_if
// and the block itself.
`timescale 1ns / 1ps

module testbench import rmva_pkg::*; ();

  localparam int LANES         = 4;
  localparam int NUM_REGS      = 3 * LANES + 1;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 250;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 100;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SRC_IDLE[PHASES]   = '{0, 51, 0, 28, 0};
  localparam int SNK_STALL[PHASES]  = '{0, 0, 51, 28, 0};

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  typedef struct packed {
    lane_t   read_data;
    status_t status;
  } bus_reply_t;

  typedef struct packed {
    logic              access;
    logic [ADDR_W-1:0] addr;
    lane_t             data;
    bit                typed;
    lane_t             rd;
    status_t           st;
  } access_row_t;

  localparam int DIRECTED_ROWS = 26;

  logic clk = 1'b0;
  logic rst;

  rmva_req_if req ();
  rmva_rsp_if rsp ();

  register_mapped_vector_alu #(.LANES(LANES)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #6 clk = ~clk;

  // control at 0, first vector 1..LANES, second vector next, result vector last
  lane_t       reg_image [NUM_REGS];
  bus_reply_t  replies_due [$];
  int          src_idle_pct;
  int          snk_stall_pct;
  int          hold_left;
  int          errors;
  int          quiet_cycles;

  function automatic void predict_access(input logic access, input logic [ADDR_W-1:0] addr,
                                         input lane_t data, output lane_t rd,
                                         output status_t st);
    int    slot;
    bit    div_fail;
    op_t   op;
    lane_t x;
    lane_t y;
    rd = '0;
    st = ST_OK;
    slot = int'(addr >> STEP_SHIFT);
    if (addr[STEP_SHIFT-1:0] != '0 || slot > 3 * LANES) begin
      st = ST_BAD_ADDR;
      return;
    end
    if (access == ACC_READ) begin
      rd = reg_image[slot];
      return;
    end
    reg_image[slot] = data;
    reg_image[0] = reg_image[0] & READY_CLEAR;
    op = op_t'(reg_image[0][OP_LSB +: OP_W]);
    div_fail = 1'b0;
    if (op == OP_DIV) begin
      for (int i = 0; i < LANES; i++) begin
        if (reg_image[1 + LANES + i] == '0) div_fail = 1'b1;
      end
    end
    if (div_fail) begin
      st = ST_DIV_ZERO;
      return;
    end
    for (int i = 0; i < LANES; i++) begin
      x = reg_image[1 + i];
      y = reg_image[1 + LANES + i];
      case (op)
        OP_ADD: reg_image[1 + 2 * LANES + i] = x + y;
        OP_SUB: reg_image[1 + 2 * LANES + i] = x - y;
        OP_MUL: reg_image[1 + 2 * LANES + i] = x * y;
        default: reg_image[1 + 2 * LANES + i] = x / y;
      endcase
    end
    reg_image[0] = reg_image[0] | READY_BIT;
  endfunction

  task automatic issue_access(input logic access, input logic [ADDR_W-1:0] addr,
                              input lane_t data, input bit typed, input lane_t t_rd,
                              input status_t t_st);
    bus_reply_t due;
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.operation  <= access;
    req.address    <= addr;
    req.write_data <= data;
    do @(posedge clk); while (req.ready !== 1'b1);
    predict_access(access, addr, data, due.read_data, due.status);
    if (typed) begin
      due.read_data = t_rd;
      due.status    = t_st;
    end
    replies_due.push_back(due);
  endtask

  always @(posedge clk) begin : response_side
    bus_reply_t due;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (replies_due.size() == 0) begin
          errors++;
          $display("%0t: response with none pending: read_data=%h status=%0d",
                   $time, rsp.read_data, rsp.status);
        end else begin
          due = replies_due.pop_front();
          if (rsp.read_data !== due.read_data) begin
            errors++;
            $display("%0t: read_data expected %h actual %h", $time, due.read_data,
                     rsp.read_data);
          end
          if (rsp.status !== due.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, due.status, rsp.status);
          end
        end
      end
      if (hold_left > 0) hold_left--;
      rsp.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid === 1'b1 && req.ready === 1'b1) ||
        (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    access_row_t       rows [DIRECTED_ROWS];
    logic              access;
    logic [ADDR_W-1:0] addr;
    lane_t             data;
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.operation  = ACC_READ;
    req.address    = '0;
    req.write_data = '0;
    src_idle_pct   = 0;
    snk_stall_pct  = 0;
    hold_left      = 0;
    errors         = 0;
    reg_image      = '{default: '0};
    rows = '{
      '{ACC_READ,  7'h00, 8'h00, 1'b1, 8'h00, ST_OK},
      '{ACC_READ,  7'h60, 8'h00, 1'b1, 8'h00, ST_OK},
      '{ACC_READ,  7'h01, 8'h00, 1'b1, 8'h00, ST_BAD_ADDR},
      '{ACC_READ,  7'h7f, 8'hff, 1'b1, 8'h00, ST_BAD_ADDR},
      '{ACC_READ,  7'h68, 8'h00, 1'b1, 8'h00, ST_BAD_ADDR},
      '{ACC_WRITE, 7'h65, 8'hff, 1'b1, 8'h00, ST_BAD_ADDR},
      '{ACC_WRITE, 7'h00, 8'h0c, 1'b1, 8'h00, ST_DIV_ZERO},
      '{ACC_READ,  7'h00, 8'h00, 1'b1, 8'h0c, ST_OK},
      '{ACC_WRITE, 7'h08, 8'hff, 1'b1, 8'h00, ST_DIV_ZERO},
      '{ACC_WRITE, 7'h10, 8'h80, 1'b0, 8'h00, ST_OK},
      '{ACC_WRITE, 7'h18, 8'h00, 1'b0, 8'h00, ST_OK},
      '{ACC_WRITE, 7'h20, 8'h7f, 1'b0, 8'h00, ST_OK},
      '{ACC_WRITE, 7'h28, 8'h01, 1'b0, 8'h00, ST_OK},
      '{ACC_WRITE, 7'h30, 8'hff, 1'b0, 8'h00, ST_OK},
      '{ACC_WRITE, 7'h38, 8'h02, 1'b0, 8'h00, ST_OK},
      '{ACC_WRITE, 7'h40, 8'h80, 1'b0, 8'h00, ST_OK},
      '{ACC_READ,  7'h48, 8'h00, 1'b0, 8'h00, ST_OK},
      '{ACC_WRITE, 7'h00, 8'h01, 1'b0, 8'h00, ST_OK},
      '{ACC_READ,  7'h50, 8'h00, 1'b0, 8'h00, ST_OK},
      '{ACC_WRITE, 7'h00, 8'h04, 1'b0, 8'h00, ST_OK},
      '{ACC_READ,  7'h58, 8'h00, 1'b0, 8'h00, ST_OK},
      '{ACC_WRITE, 7'h00, 8'hf8, 1'b0, 8'h00, ST_OK},
      '{ACC_READ,  7'h60, 8'h00, 1'b0, 8'h00, ST_OK},
      '{ACC_WRITE, 7'h60, 8'haa, 1'b0, 8'h00, ST_OK},
      '{ACC_READ,  7'h60, 8'h00, 1'b0, 8'h00, ST_OK},
      '{ACC_READ,  7'h00, 8'h00, 1'b0, 8'h00, ST_OK}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      issue_access(rows[r].access, rows[r].addr, rows[r].data, rows[r].typed, rows[r].rd,
                   rows[r].st);
    end

    for (int p = 0; p < PHASES; p++) begin
      src_idle_pct  = SRC_IDLE[p];
      snk_stall_pct = SNK_STALL[p];
      // last phase: response side holds off while requests keep coming
      if (p == PHASES - 1) hold_left = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        access = ($urandom_range(1) == 1) ? ACC_WRITE : ACC_READ;
        if ($urandom_range(99) < 10) addr = ADDR_W'($urandom_range(127));
        else addr = ADDR_W'($urandom_range(3 * LANES) << STEP_SHIFT);
        case ($urandom_range(9))
          0: data = 8'h00;
          1: data = 8'hff;
          default: data = lane_t'($urandom_range(255));
        endcase
        issue_access(access, addr, data, 1'b0, 8'h00, ST_OK);
      end
    end

    req.valid <= 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
